@@ design/ahbr_pkg.sv @@
`timescale 1ns / 1ps

package ahbr_pkg;

  // Action codes carried in the action field of an input transfer.
  localparam logic [2:0] ACT_WRITE    = 3'd0;
  localparam logic [2:0] ACT_RESTART  = 3'd1;
  localparam logic [2:0] ACT_LITERAL  = 3'd2;
  localparam logic [2:0] ACT_SLITERAL = 3'd3;
  localparam logic [2:0] ACT_UVLC     = 3'd4;
  localparam logic [2:0] ACT_TRAILING = 3'd5;
  localparam logic [2:0] ACT_UNIFORM  = 3'd6;

  // Status codes of a result transfer.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TRAIL_BAD = 2'd1;
  localparam logic [1:0] STATUS_UVLC_END  = 2'd2;

  localparam int unsigned LEN_W   = 13;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic [2:0]  action;
    logic [11:0] byte_address;
    logic [7:0]  byte_data;
    logic [5:0]  bit_count;
    logic [15:0] symbol_count;
  } in_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [12:0] bytes_consumed;
  } out_t;

endpackage

@@ design/av1_header_bit_reader.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Ports                            Transfer when
// input     in         start, busy, in_data             start high and busy low at a rising edge
// result    out        out_strobe, out_data             out_strobe high, one cycle per result
// config    in         cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready both high
//
// An action runs from one accepted input transfer through START, then SHIFT for each
// bit read from the buffer, whose registered read port holds the byte under the position,
// or SCAN for a uvlc prefix and UNI_CHK for a uniform code's final check, to DONE and IDLE.
// Reset (rst_n low at a rising edge) clears the bit position and
// buffer_length; the buffer stays undefined until written. The receiver cannot stall:
// each result is shown for exactly one cycle while busy is high.
module av1_header_bit_reader #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ahbr_pkg::in_t   in_data,
  output logic            out_strobe,
  output ahbr_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [12:0]     cfg_data
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned IDX_W  = ahbr_pkg::POS_W - 3;
  localparam logic [16:0] BUF_BYTES_L = 17'(BUFFER_BYTES);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_START   = 6'b000010,
    ST_SHIFT   = 6'b000100,
    ST_SCAN    = 6'b001000,
    ST_UNI_CHK = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  // What each bit shifted in the SHIFT state does to the accumulator.
  typedef enum logic [2:0] {
    MODE_LIT   = 3'd0,
    MODE_SLIT  = 3'd1,
    MODE_UVLC  = 3'd2,
    MODE_TRAIL = 3'd3,
    MODE_UNI   = 3'd4
  } mode_t;

  // Bit length of a 16-bit symbol count.
  function automatic logic [4:0] bit_length(input logic [15:0] n);
    logic [4:0] len;
    len = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (n[i]) len = 5'(i + 1);
    end
    return len;
  endfunction

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  ahbr_pkg::in_t item_r;

  logic [ahbr_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [ahbr_pkg::LEN_W-1:0]   buf_len_r;
  logic [ahbr_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic [5:0]                   cnt_r, cnt_nxt;
  logic [5:0]                   zeros_r, zeros_nxt;
  logic                         first_r, first_nxt;
  logic [16:0]                  m_r, m_nxt;

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rd_data_r;
  logic       wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [IDX_W+ADDR_W-1:0] rd_idx_ext;
  logic [12+ADDR_W-1:0]    wr_idx_ext;

  // Bit engine signals.
  logic [IDX_W-1:0] idx;
  logic [16:0]      valid_bytes;
  logic [16:0]      len_ext;
  logic             at_end;
  logic             cur_bit;
  logic             take;

  logic [4:0]  uni_len;
  logic [15:0] uni_v;
  logic [16:0] uni_sum;
  logic [16:0] bytes_sum;

  assign cfg_ready  = 1'b1;
  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = (state_r == ST_DONE);

  // The reader never looks beyond min(buffer_length, BUFFER_BYTES) bytes.
  assign len_ext     = {4'd0, buf_len_r};
  assign valid_bytes = (len_ext < BUF_BYTES_L) ? len_ext : BUF_BYTES_L;

  // A bit at or past the end reads as zero and leaves the position alone.
  assign idx     = pos_r[ahbr_pkg::POS_W-1:3];
  assign at_end  = ({4'd0, idx} >= valid_bytes);
  assign cur_bit = at_end ? 1'b0 : rd_data_r[~pos_r[2:0]];

  assign uni_len = bit_length(item_r.symbol_count);
  assign uni_v   = value_r[15:0];
  assign uni_sum = {uni_v, 1'b0} - m_r + {16'd0, cur_bit};

  // The read address follows the next position, so rd_data_r is registered together
  // with pos_r and holds the byte under the current position.
  assign rd_idx_ext = {{ADDR_W{1'b0}}, pos_nxt[ahbr_pkg::POS_W-1:3]};
  assign rd_addr    = rd_idx_ext[ADDR_W-1:0];
  assign wr_idx_ext = {{ADDR_W{1'b0}}, item_r.byte_address};
  assign wr_addr    = wr_idx_ext[ADDR_W-1:0];
  assign wr_en      = (state_r == ST_START) && (item_r.action == ahbr_pkg::ACT_WRITE) &&
                      ({5'd0, item_r.byte_address} < BUF_BYTES_L);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= item_r.byte_data;
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    value_nxt  = value_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    zeros_nxt  = zeros_r;
    first_nxt  = first_r;
    m_nxt      = m_r;
    take       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_START;
      end

      ST_START: begin
        value_nxt  = '0;
        status_nxt = ahbr_pkg::STATUS_OK;
        zeros_nxt  = '0;
        first_nxt  = 1'b1;
        state_nxt  = ST_DONE;
        case (item_r.action)
          ahbr_pkg::ACT_RESTART: begin
            pos_nxt = '0;
          end
          ahbr_pkg::ACT_LITERAL: begin
            mode_nxt = MODE_LIT;
            cnt_nxt  = (item_r.bit_count > 6'd32) ? 6'd32 : item_r.bit_count;
            if (cnt_nxt != 6'd0) state_nxt = ST_SHIFT;
          end
          ahbr_pkg::ACT_SLITERAL: begin
            mode_nxt  = MODE_SLIT;
            cnt_nxt   = (item_r.bit_count >= 6'd32) ? 6'd32 : item_r.bit_count + 6'd1;
            state_nxt = ST_SHIFT;
          end
          ahbr_pkg::ACT_UVLC: begin
            state_nxt = ST_SCAN;
          end
          ahbr_pkg::ACT_TRAILING: begin
            mode_nxt  = MODE_TRAIL;
            cnt_nxt   = 6'd8 - {3'd0, pos_r[2:0]};
            state_nxt = ST_SHIFT;
          end
          ahbr_pkg::ACT_UNIFORM: begin
            mode_nxt = MODE_UNI;
            m_nxt    = (17'd1 << uni_len) - {1'b0, item_r.symbol_count};
            cnt_nxt  = {1'b0, uni_len} - 6'd1;
            if (item_r.symbol_count == 16'd0) begin
              state_nxt = ST_DONE;
            end else if (uni_len == 5'd1) begin
              state_nxt = ST_UNI_CHK;
            end else begin
              state_nxt = ST_SHIFT;
            end
          end
          default: begin
            // Byte writes happen through wr_en; the spare code does nothing.
          end
        endcase
      end

      ST_SHIFT: begin
        take      = 1'b1;
        first_nxt = 1'b0;
        cnt_nxt   = cnt_r - 6'd1;
        case (mode_r)
          MODE_SLIT: begin
            // The first bit fills the whole word, which sign-extends the result.
            value_nxt = first_r ? {32{cur_bit}} : {value_r[30:0], cur_bit};
          end
          MODE_UVLC: begin
            value_nxt = {value_r[30:0], 1'b0} + 32'd1 + {31'd0, cur_bit};
          end
          MODE_TRAIL: begin
            // Expect a one, then zeros up to the byte boundary.
            if (cur_bit != first_r) status_nxt = ahbr_pkg::STATUS_TRAIL_BAD;
          end
          default: begin
            value_nxt = {value_r[30:0], cur_bit};
          end
        endcase
        if (cnt_r == 6'd1) begin
          state_nxt = (mode_r == MODE_UNI) ? ST_UNI_CHK : ST_DONE;
        end
      end

      ST_SCAN: begin
        if (at_end) begin
          value_nxt  = '0;
          status_nxt = ahbr_pkg::STATUS_UVLC_END;
          state_nxt  = ST_DONE;
        end else begin
          take = 1'b1;
          if (cur_bit) begin
            mode_nxt = MODE_UVLC;
            cnt_nxt  = zeros_r;
            if (zeros_r[5]) begin
              value_nxt = '1;
              state_nxt = ST_DONE;
            end else if (zeros_r == 6'd0) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_SHIFT;
            end
          end else if (!zeros_r[5]) begin
            // The count saturates at 32, which is all that matters afterward.
            zeros_nxt = zeros_r + 6'd1;
          end
        end
      end

      ST_UNI_CHK: begin
        state_nxt = ST_DONE;
        if ({1'b0, uni_v} >= m_r) begin
          take      = 1'b1;
          value_nxt = {15'd0, uni_sum};
        end
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (take && !at_end) pos_nxt = pos_r + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      buf_len_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (cfg_valid && cfg_ready) buf_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) item_r <= in_data;
    mode_r   <= mode_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
    cnt_r    <= cnt_nxt;
    zeros_r  <= zeros_nxt;
    first_r  <= first_nxt;
    m_r      <= m_nxt;
  end

  // Bytes consumed is the bit position rounded up to whole bytes.
  assign bytes_sum = {1'b0, pos_r} + 17'd7;

  always_comb begin
    out_data.value          = value_r;
    out_data.status         = status_r;
    out_data.bytes_consumed = bytes_sum[15:3];
  end

endmodule

@@ sim/av1_header_bit_reader_tb.sv @@
`timescale 1ns / 1ps

module av1_header_bit_reader_tb;

  localparam int unsigned BUFFER_BYTES = 4096;
  // Random traffic after the directed checks. The count includes byte writes.
  localparam int unsigned RANDOM_ITEMS = 950;
  // The slowest legal run stays well below this. It covers long uvlc scans and
  // the widest sender gaps on every item.
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  // The package has no name for the spare action code, which the block treats
  // as a no-op.
  localparam logic [2:0]  ACT_NOP      = 3'd7;

  logic           clk;
  logic           rst_n      = 1'b0;
  logic           start      = 1'b0;
  logic           busy;
  ahbr_pkg::in_t  in_data    = '0;
  logic           out_strobe;
  ahbr_pkg::out_t out_data;
  logic           cfg_valid  = 1'b0;
  logic           cfg_ready;
  logic [12:0]    cfg_data   = '0;

  av1_header_bit_reader #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The testbench keeps its own copy of the reader state. The known flags record
  // which bytes have been written. A read that would touch an unwritten byte
  // inside the valid length is outside the contract, so it is never sent.
  logic [7:0]  byte_image [BUFFER_BYTES];
  bit          byte_known [BUFFER_BYTES];
  int unsigned read_pos;
  logic [12:0] length_reg;
  bit          stray_read;

  // These are the decoded fields that the block still owes, oldest first.
  ahbr_pkg::out_t pending_fields [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned burst_left;
  bit          steady_sender;

  function automatic int unsigned usable_bytes();
    return (length_reg < BUFFER_BYTES) ? int'(length_reg) : BUFFER_BYTES;
  endfunction

  // A read at or past the end of the valid bytes gives 0 and leaves the
  // position where it is.
  function automatic logic next_bit();
    int unsigned idx;
    logic        b;
    idx = read_pos >> 3;
    if (idx >= usable_bytes()) return 1'b0;
    if (!byte_known[idx]) stray_read = 1'b1;
    b = byte_image[idx][7 - (read_pos & 7)];
    read_pos++;
    return b;
  endfunction

  function automatic logic [31:0] next_bits(int unsigned width);
    logic [31:0] v;
    int unsigned i;
    v = '0;
    if (width > 32) width = 32;
    for (i = 0; i < width; i++) v = {v[30:0], next_bit()};
    return v;
  endfunction

  // This applies one action to the local state and returns the field that the
  // block must report for it.
  function automatic ahbr_pkg::out_t decode_field(ahbr_pkg::in_t item);
    ahbr_pkg::out_t r;
    int unsigned    w;
    int unsigned    zeros;
    int unsigned    k;
    int unsigned    n;
    int unsigned    len;
    logic [31:0]    v;
    logic [31:0]    m;
    bit             done;
    bit             ran_out;
    r = '0;
    case (item.action)
      ahbr_pkg::ACT_WRITE: begin
        byte_image[item.byte_address] = item.byte_data;
        byte_known[item.byte_address] = 1'b1;
      end
      ahbr_pkg::ACT_RESTART: begin
        read_pos = 0;
      end
      ahbr_pkg::ACT_LITERAL: begin
        r.value = next_bits(32'(item.bit_count));
      end
      ahbr_pkg::ACT_SLITERAL: begin
        // The width saturates at 32 bits, and a full 32-bit read is left as it is.
        w = 32'(item.bit_count) + 1;
        if (w > 32) w = 32;
        v = next_bits(w);
        if (w < 32 && v[w-1]) v = v | (32'hFFFF_FFFF << w);
        r.value = v;
      end
      ahbr_pkg::ACT_UVLC: begin
        zeros   = 0;
        done    = 1'b0;
        ran_out = 1'b0;
        while (!done) begin
          if ((read_pos >> 3) >= usable_bytes()) begin
            ran_out = 1'b1;
            done    = 1'b1;
          end else if (next_bit()) begin
            done = 1'b1;
          end else begin
            zeros++;
          end
        end
        // A scan that runs off the end stops there and flags it. A run of 32
        // or more zeros still takes the terminating one and saturates.
        if (ran_out) begin
          r.status = ahbr_pkg::STATUS_UVLC_END;
        end else if (zeros >= 32) begin
          r.value = '1;
        end else begin
          r.value = ((32'd1 << zeros) - 32'd1) + next_bits(zeros);
        end
      end
      ahbr_pkg::ACT_TRAILING: begin
        // The check reads up to the next byte boundary, which is a full byte
        // when already aligned. Only a one followed by zeros passes.
        k = 8 - (read_pos & 7);
        v = next_bits(k);
        if (v != (32'd1 << (k - 1))) r.status = ahbr_pkg::STATUS_TRAIL_BAD;
      end
      ahbr_pkg::ACT_UNIFORM: begin
        n = 32'(item.symbol_count);
        if (n != 0) begin
          len = 0;
          while (len < 17 && (n >> len) != 0) len++;
          m = (32'd1 << len) - n;
          v = next_bits(len - 1);
          if (v < m) r.value = v;
          else r.value = (v << 1) - m + 32'(next_bit());
        end
      end
      default: begin
      end
    endcase
    r.bytes_consumed = 13'((read_pos + 7) >> 3);
    return r;
  endfunction

  // Every mismatch is counted and printed on one line.
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h",
             cycle_count, what, got, want);
  endtask

  // The receiver cannot hold results off, so every strobe is a result transfer.
  // It is compared field by field with the oldest field still owed.
  always @(posedge clk) begin
    ahbr_pkg::out_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_fields.size() == 0) begin
        flag_mismatch("result with nothing owed, value", out_data.value, 32'h0);
      end else begin
        want = pending_fields.pop_front();
        if (out_data.value !== want.value)
          flag_mismatch("value", out_data.value, want.value);
        if (out_data.status !== want.status)
          flag_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.bytes_consumed !== want.bytes_consumed)
          flag_mismatch("bytes_consumed", 32'(out_data.bytes_consumed),
                        32'(want.bytes_consumed));
      end
    end
  end

  // A hung block must not hang the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Fields that an action does not use still get random values, so every input
  // bit toggles during the run.
  function automatic ahbr_pkg::in_t read_item(input logic [2:0] act,
                                              input logic [5:0] count,
                                              input logic [15:0] nsym);
    ahbr_pkg::in_t it;
    it.action       = act;
    it.byte_address = 12'($urandom);
    it.byte_data    = 8'($urandom);
    it.bit_count    = count;
    it.symbol_count = nsym;
    return it;
  endfunction

  function automatic ahbr_pkg::in_t write_item(input logic [11:0] addr,
                                               input logic [7:0] data);
    ahbr_pkg::in_t it;
    it              = read_item(ahbr_pkg::ACT_WRITE, 6'($urandom), 16'($urandom));
    it.byte_address = addr;
    it.byte_data    = data;
    return it;
  endfunction

  // Byte contents lean toward zero runs and lone ones. These give long uvlc
  // prefixes and trailing patterns that pass the check.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h00;
      3, 4, 5: return 8'h80 >> $urandom_range(0, 7);
      6:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // This sends one input transfer. The sender works in bursts. Between bursts it
  // lowers start for a random gap, unless the current phase runs without gaps.
  // Start is left high on return, so back-to-back items never lower and raise it
  // in one time step. A read that would touch an unwritten byte becomes a
  // restart before it is sent.
  task automatic send_field(input ahbr_pkg::in_t item);
    int unsigned    saved_pos;
    int unsigned    gap;
    ahbr_pkg::out_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    saved_pos  = read_pos;
    stray_read = 1'b0;
    r = decode_field(item);
    if (stray_read) begin
      read_pos    = saved_pos;
      item.action = ahbr_pkg::ACT_RESTART;
      r = decode_field(item);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    // The transfer happened at this edge, so its result is queued before the block
    // can show it.
    pending_fields.push_back(r);
    items_sent++;
  endtask

  // This holds the sender off until every owed result has arrived and the block
  // reports idle.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (busy !== 1'b0 || pending_fields.size() != 0);
  endtask

  // The length register is written only while the block is idle.
  task automatic write_buffer_length(input logic [12:0] len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    length_reg  = len;
  endtask

  // With a zero length every read finds the end at once. A uvlc flags the
  // overrun, the trailing check fails, and the position never moves.
  task automatic test_empty_buffer();
    write_buffer_length(13'd0);
    send_field(read_item(ahbr_pkg::ACT_LITERAL, 6'd32, 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_UVLC, 6'($urandom), 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_TRAILING, 6'($urandom), 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_UNIFORM, 6'($urandom), 16'd0));
    send_field(read_item(ACT_NOP, 6'($urandom), 16'($urandom)));
  endtask

  // The buffer holds 32 zeros and a one, then a sign-extendable nibble, a
  // trailing pattern that passes, and an aligned 0x80. These cover the saturated
  // uvlc, sign extension, both trailing outcomes, an overrun at the end, and
  // 32-bit reads that cross the end.
  task automatic test_edge_fields();
    send_field(write_item(12'd0, 8'h00));
    send_field(write_item(12'd1, 8'h00));
    send_field(write_item(12'd2, 8'h00));
    send_field(write_item(12'd3, 8'h00));
    send_field(write_item(12'd4, 8'h80));
    send_field(write_item(12'd5, 8'hC8));
    send_field(write_item(12'd6, 8'h80));
    write_buffer_length(13'd7);
    send_field(read_item(ahbr_pkg::ACT_UVLC, 6'($urandom), 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_LITERAL, 6'd7, 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_SLITERAL, 6'd3, 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_TRAILING, 6'($urandom), 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_TRAILING, 6'($urandom), 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_UVLC, 6'($urandom), 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_TRAILING, 6'($urandom), 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_RESTART, 6'($urandom), 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_SLITERAL, 6'd63, 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_LITERAL, 6'd63, 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_RESTART, 6'($urandom), 16'($urandom)));
    send_field(read_item(ahbr_pkg::ACT_UNIFORM, 6'($urandom), 16'hFFFF));
    send_field(read_item(ahbr_pkg::ACT_UNIFORM, 6'($urandom), 16'd3));
  endtask

  // Random traffic runs in phases. Each phase sets a length, loads the front of
  // the buffer with fresh bytes, restarts, and then parses a random mix of
  // syntax elements. The mix also holds restarts, stray writes, no-ops and full
  // pauses. The first phases use the length extremes.
  task automatic test_random_fields();
    int unsigned first;
    int unsigned phase;
    int unsigned fill;
    int unsigned reads;
    int unsigned i;
    int unsigned sel;
    logic [12:0] len;
    logic [5:0]  count;
    logic [15:0] nsym;
    logic [2:0]  act;
    first = items_sent;
    phase = 0;
    while (items_sent - first < RANDOM_ITEMS) begin
      case (phase)
        0: len = 13'd8191;
        1: len = 13'd4096;
        2: len = 13'd1;
        default: begin
          case ($urandom_range(0, 9))
            0:       len = 13'd0;
            1:       len = 13'($urandom);
            2:       len = 13'd4096;
            default: len = 13'($urandom_range(1, 24));
          endcase
        end
      endcase
      steady_sender = ($urandom_range(0, 3) == 0);
      write_buffer_length(len);
      fill = (len < 40) ? int'(len) : $urandom_range(16, 40);
      for (i = 0; i < fill; i++) send_field(write_item(12'(i), random_byte()));
      send_field(read_item(ahbr_pkg::ACT_RESTART, 6'($urandom), 16'($urandom)));
      reads = $urandom_range(15, 60);
      for (i = 0; i < reads; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          send_field(read_item(ahbr_pkg::ACT_RESTART, 6'($urandom), 16'($urandom)));
        end else if (sel < 12) begin
          if (fill > 0 && $urandom_range(0, 1) == 0)
            send_field(write_item(12'($urandom_range(0, fill - 1)), random_byte()));
          else
            send_field(write_item(12'($urandom), random_byte()));
        end else if (sel < 15) begin
          send_field(read_item(ACT_NOP, 6'($urandom), 16'($urandom)));
        end else if (sel < 17) begin
          drain_results();
        end else begin
          count = ($urandom_range(0, 2) == 0) ? 6'($urandom) : 6'($urandom_range(0, 16));
          case ($urandom_range(0, 2))
            0: nsym = 16'($urandom_range(0, 20));
            1: nsym = 16'((32'd1 << $urandom_range(0, 15)) + $urandom_range(0, 2) - 1);
            default: nsym = 16'($urandom);
          endcase
          case ($urandom_range(0, 4))
            0:       act = ahbr_pkg::ACT_LITERAL;
            1:       act = ahbr_pkg::ACT_SLITERAL;
            2:       act = ahbr_pkg::ACT_UVLC;
            3:       act = ahbr_pkg::ACT_TRAILING;
            default: act = ahbr_pkg::ACT_UNIFORM;
          endcase
          send_field(read_item(act, count, nsym));
        end
      end
      phase++;
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    items_sent     = 0;
    burst_left     = 0;
    steady_sender  = 1'b0;
    read_pos       = 0;
    length_reg     = '0;
    foreach (byte_known[i]) byte_known[i] = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_buffer();
    test_edge_fields();
    test_random_fields();

    // Wait for the last result, then wait on to catch any stray strobe.
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
